FILE: rtl/core/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and constants of the Morse pulse sequencer: register map,
// sequencer states and the character code table.
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int CFG_BITS   = 16;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;
    localparam int CODE_BITS  = 6;
    localparam int LEN_BITS   = 3;
    localparam int CNT_BITS   = 4;

    localparam logic [CNT_BITS-1:0] FLAG_LAST = 4'd9;

    localparam logic [2:0] REG_DOT        = 3'd0;
    localparam logic [2:0] REG_DASH       = 3'd1;
    localparam logic [2:0] REG_ELEM_GAP   = 3'd2;
    localparam logic [2:0] REG_LETTER_GAP = 3'd3;
    localparam logic [2:0] REG_WORD_GAP   = 3'd4;
    localparam logic [2:0] REG_FLAG       = 3'd5;
    localparam logic [2:0] REG_FRAME_GAP  = 3'd6;

    localparam logic [CFG_BITS-1:0] DOT_RESET        = 16'd100;
    localparam logic [CFG_BITS-1:0] DASH_RESET       = 16'd300;
    localparam logic [CFG_BITS-1:0] ELEM_GAP_RESET   = 16'd100;
    localparam logic [CFG_BITS-1:0] LETTER_GAP_RESET = 16'd300;
    localparam logic [CFG_BITS-1:0] WORD_GAP_RESET   = 16'd700;
    localparam logic [CFG_BITS-1:0] FLAG_RESET       = 16'd50;
    localparam logic [CFG_BITS-1:0] FRAME_GAP_RESET  = 16'd1000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OPEN_GAP,
        ST_OPEN_FLAG,
        ST_OPEN_GAP2,
        ST_BODY_ON,
        ST_BODY_OFF,
        ST_LETTER_GAP,
        ST_WORD_GAP,
        ST_END_GAP,
        ST_CLOSE_FLAG,
        ST_CLOSE_GAP
    } mps_state_t;

    // pat is left-aligned, first element in the top bit, 1 is a dash
    typedef struct packed {
        logic [LEN_BITS-1:0]  len;
        logic [CODE_BITS-1:0] pat;
    } mps_code_t;

    function automatic logic [7:0] mps_upper(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c inside {[8'h61:8'h7A]}) begin
            u = c - 8'h20;
        end
        return u;
    endfunction

    function automatic mps_code_t mps_lookup(input logic [7:0] c);
        mps_code_t e;
        case (c)
            "@":     e = '{3'd6, 6'b011010};
            "A":     e = '{3'd2, 6'b010000};
            "B":     e = '{3'd4, 6'b100000};
            "C":     e = '{3'd4, 6'b101000};
            "D":     e = '{3'd3, 6'b100000};
            "E":     e = '{3'd1, 6'b000000};
            "F":     e = '{3'd4, 6'b001000};
            "G":     e = '{3'd3, 6'b110000};
            "H":     e = '{3'd4, 6'b000000};
            "I":     e = '{3'd2, 6'b000000};
            "J":     e = '{3'd4, 6'b011100};
            "K":     e = '{3'd3, 6'b101000};
            "L":     e = '{3'd4, 6'b010000};
            "M":     e = '{3'd2, 6'b110000};
            "N":     e = '{3'd2, 6'b100000};
            "O":     e = '{3'd3, 6'b111000};
            "P":     e = '{3'd4, 6'b011000};
            "Q":     e = '{3'd4, 6'b110100};
            "R":     e = '{3'd3, 6'b010000};
            "S":     e = '{3'd3, 6'b000000};
            "T":     e = '{3'd1, 6'b100000};
            "U":     e = '{3'd3, 6'b001000};
            "V":     e = '{3'd4, 6'b000100};
            "W":     e = '{3'd3, 6'b011000};
            "X":     e = '{3'd4, 6'b100100};
            "Y":     e = '{3'd4, 6'b101100};
            "Z":     e = '{3'd4, 6'b110000};
            ".":     e = '{3'd6, 6'b010101};
            ",":     e = '{3'd6, 6'b110011};
            "/":     e = '{3'd5, 6'b100100};
            "1":     e = '{3'd5, 6'b011110};
            "2":     e = '{3'd5, 6'b001110};
            "3":     e = '{3'd5, 6'b000110};
            "4":     e = '{3'd5, 6'b000010};
            "5":     e = '{3'd5, 6'b000000};
            "6":     e = '{3'd5, 6'b100000};
            "7":     e = '{3'd5, 6'b110000};
            "8":     e = '{3'd5, 6'b111000};
            "9":     e = '{3'd5, 6'b111100};
            "0":     e = '{3'd5, 6'b111110};
            default: e = '{3'd6, 6'b001100};
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/core/morse_pulse_sequencer_core.sv
// ----------------------------------------------------------------------------
// morse_pulse_sequencer_core
// Turns message characters into LED (level, duration) intervals, with opening
// and closing flag sequences around each message.
// ----------------------------------------------------------------------------
//  channel | ports                                   | beat
//  s_      | s_char_code, s_is_first, s_is_last      | one character
//  m_      | m_led_on, m_duration_ms, m_run_end      | one LED interval
//  apb     | psel, penable, pwrite, paddr, pwdata    | one register write/read
//
// A character is accepted, then its intervals are emitted in turn; the sequencer
// emits one interval per cycle into the output register while m_ is not stalled.
// s_ready is high only while the sequencer is idle.
// A stalled m_ beat holds the sequencer in place.
// aresetn is synchronous; registers return to their default timings.
// ----------------------------------------------------------------------------
module morse_pulse_sequencer_core #(
    parameter int DURATION_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_char_code,
    input  logic                           s_is_first,
    input  logic                           s_is_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_led_on,
    output logic [15:0]                    m_duration_ms,
    output logic                           m_run_end,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mps_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [mps_pkg::DATA_BITS-1:0]  pwdata,
    output logic [mps_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);
    import mps_pkg::*;

    localparam int DUR_KEEP = (DURATION_BITS < CFG_BITS) ? DURATION_BITS : CFG_BITS;

    logic [CFG_BITS-1:0] dot_reg, dash_reg, elem_gap_reg, letter_gap_reg;
    logic [CFG_BITS-1:0] word_gap_reg, flag_reg, frame_gap_reg;

    mps_state_t           state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [CODE_BITS-1:0] pat_reg, pat_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic                 space_reg, space_next;
    logic                 last_reg, last_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_led_on_reg;
    logic [DUR_KEEP-1:0]  m_dur_reg;
    logic                 m_run_end_reg;

    logic                 cfg_wr;
    logic [2:0]           cfg_idx;
    logic [7:0]           in_upper;
    mps_code_t            in_code;
    logic                 in_space;
    logic                 accept;
    logic                 fire;
    logic                 step;
    logic                 emit_level;
    logic [CFG_BITS-1:0]  emit_dur;
    logic                 emit_last;
    logic [CFG_BITS-1:0]  end_gap;
    mps_state_t           after_open_in, after_open_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        case (cfg_idx)
            REG_DOT:        prdata = DATA_BITS'(dot_reg);
            REG_DASH:       prdata = DATA_BITS'(dash_reg);
            REG_ELEM_GAP:   prdata = DATA_BITS'(elem_gap_reg);
            REG_LETTER_GAP: prdata = DATA_BITS'(letter_gap_reg);
            REG_WORD_GAP:   prdata = DATA_BITS'(word_gap_reg);
            REG_FLAG:       prdata = DATA_BITS'(flag_reg);
            REG_FRAME_GAP:  prdata = DATA_BITS'(frame_gap_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg        <= DOT_RESET;
            dash_reg       <= DASH_RESET;
            elem_gap_reg   <= ELEM_GAP_RESET;
            letter_gap_reg <= LETTER_GAP_RESET;
            word_gap_reg   <= WORD_GAP_RESET;
            flag_reg       <= FLAG_RESET;
            frame_gap_reg  <= FRAME_GAP_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DOT:        dot_reg        <= pwdata[CFG_BITS-1:0];
                REG_DASH:       dash_reg       <= pwdata[CFG_BITS-1:0];
                REG_ELEM_GAP:   elem_gap_reg   <= pwdata[CFG_BITS-1:0];
                REG_LETTER_GAP: letter_gap_reg <= pwdata[CFG_BITS-1:0];
                REG_WORD_GAP:   word_gap_reg   <= pwdata[CFG_BITS-1:0];
                REG_FLAG:       flag_reg       <= pwdata[CFG_BITS-1:0];
                REG_FRAME_GAP:  frame_gap_reg  <= pwdata[CFG_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_upper = mps_upper(s_char_code);
    assign in_code  = mps_lookup(in_upper);
    assign in_space = (in_upper inside {8'h20, 8'h0A});

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign fire     = !m_valid_reg || m_ready;
    assign step     = fire && (state_reg != ST_IDLE);

    assign end_gap  = (frame_gap_reg > letter_gap_reg) ? (frame_gap_reg - letter_gap_reg) : '0;

    always_comb begin
        after_open_in = ST_BODY_ON;
        if (in_space) begin
            after_open_in = s_is_last ? ST_END_GAP : ST_WORD_GAP;
        end
        after_open_reg = ST_BODY_ON;
        if (space_reg) begin
            after_open_reg = last_reg ? ST_END_GAP : ST_WORD_GAP;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = s_is_first ? ST_OPEN_GAP : after_open_in;
                end
            end
            ST_OPEN_GAP: begin
                if (step) state_next = ST_OPEN_FLAG;
            end
            ST_OPEN_FLAG: begin
                if (step && cnt_reg == '0) state_next = ST_OPEN_GAP2;
            end
            ST_OPEN_GAP2: begin
                if (step) state_next = after_open_reg;
            end
            ST_BODY_ON: begin
                if (step) state_next = ST_BODY_OFF;
            end
            ST_BODY_OFF: begin
                if (step) begin
                    state_next = (cnt_reg == CNT_BITS'(1)) ? ST_LETTER_GAP : ST_BODY_ON;
                end
            end
            ST_LETTER_GAP: begin
                if (step) state_next = last_reg ? ST_END_GAP : ST_IDLE;
            end
            ST_WORD_GAP: begin
                if (step) state_next = ST_IDLE;
            end
            ST_END_GAP: begin
                if (step) state_next = ST_CLOSE_FLAG;
            end
            ST_CLOSE_FLAG: begin
                if (step && cnt_reg == '0) state_next = ST_CLOSE_GAP;
            end
            ST_CLOSE_GAP: begin
                if (step) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        emit_level = 1'b0;
        emit_dur   = frame_gap_reg;
        emit_last  = 1'b0;
        cnt_next   = cnt_reg;
        pat_next   = pat_reg;
        len_next   = len_reg;
        space_next = space_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next   = CNT_BITS'(in_code.len);
                    pat_next   = in_code.pat;
                    len_next   = in_code.len;
                    space_next = in_space;
                    last_next  = s_is_last;
                end
            end
            ST_OPEN_GAP, ST_END_GAP: begin
                if (state_reg == ST_END_GAP) emit_dur = end_gap;
                if (step) cnt_next = FLAG_LAST;
            end
            ST_OPEN_FLAG, ST_CLOSE_FLAG: begin
                emit_level = cnt_reg[0];
                emit_dur   = flag_reg;
                if (step) cnt_next = cnt_reg - CNT_BITS'(1);
            end
            ST_OPEN_GAP2: begin
                if (step) cnt_next = CNT_BITS'(len_reg);
            end
            ST_BODY_ON: begin
                emit_level = 1'b1;
                emit_dur   = pat_reg[CODE_BITS-1] ? dash_reg : dot_reg;
                if (step) pat_next = {pat_reg[CODE_BITS-2:0], 1'b0};
            end
            ST_BODY_OFF: begin
                emit_dur = elem_gap_reg;
                if (step) cnt_next = cnt_reg - CNT_BITS'(1);
            end
            ST_LETTER_GAP: begin
                emit_dur  = letter_gap_reg;
                emit_last = !last_reg;
            end
            ST_WORD_GAP: begin
                emit_dur  = word_gap_reg;
                emit_last = 1'b1;
            end
            ST_CLOSE_GAP: begin
                emit_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pat_reg   <= pat_next;
        len_reg   <= len_next;
        space_reg <= space_next;
        last_reg  <= last_next;
        if (step) begin
            m_led_on_reg  <= emit_level;
            m_dur_reg     <= emit_dur[DUR_KEEP-1:0];
            m_run_end_reg <= emit_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_led_on      = m_led_on_reg;
    assign m_duration_ms = 16'(m_dur_reg);
    assign m_run_end     = m_run_end_reg;

endmodule

FILE: rtl/core/mps_checker.sv
// ----------------------------------------------------------------------------
// mps_checker
// Port-level checks of the Morse pulse sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module mps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_led_on,
    input logic [15:0] m_duration_ms,
    input logic        m_run_end
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready again before results of the beat were produced");

    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_end |-> !s_ready)
        else $error("input ready while a run is still unfinished");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_on)
                                && $stable(m_duration_ms) && $stable(m_run_end))
        else $error("stalled result beat changed");

endmodule

bind morse_pulse_sequencer_core mps_checker u_mps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_led_on      (m_led_on),
    .m_duration_ms (m_duration_ms),
    .m_run_end     (m_run_end)
);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for morse_pulse_sequencer_core. Message characters go in
// over the s_ channel, and each one builds the LED intervals it should produce
// from its own character code table and a shadow of the timing registers.
// Every m_ beat is compared field by field with the oldest pending interval.
// Timings are reprogrammed over APB between drained phases (zero, max, short,
// letter gap above frame gap, random) and read back. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mps_pkg::*;

    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam int         FLAG_PAIRS   = 5;
    localparam int         PHASE_COUNT  = 9;
    localparam int         PHASE_ITEMS  = 44;
    localparam int         CYCLE_LIMIT  = 1000000;

    typedef enum int {
        TP_RANDOM,
        TP_ZERO,
        TP_MAX,
        TP_LETTER_OVER_FRAME,
        TP_SHORT
    } timing_profile_t;

    typedef struct packed {
        logic        led_on;
        logic [15:0] duration_ms;
        logic        run_end;
    } interval_t;

    class led_interval_book;
        logic [15:0] timing [7];
        interval_t   due_intervals [$];
        int          errors;

        function new();
            timing[REG_DOT]        = DOT_RESET;
            timing[REG_DASH]       = DASH_RESET;
            timing[REG_ELEM_GAP]   = ELEM_GAP_RESET;
            timing[REG_LETTER_GAP] = LETTER_GAP_RESET;
            timing[REG_WORD_GAP]   = WORD_GAP_RESET;
            timing[REG_FLAG]       = FLAG_RESET;
            timing[REG_FRAME_GAP]  = FRAME_GAP_RESET;
            errors = 0;
        endfunction

        function void set_timing(logic [2:0] idx, logic [31:0] value);
            if (idx <= REG_FRAME_GAP) begin
                timing[idx] = value[15:0];
            end
        endfunction

        function string morse_of(logic [7:0] c);
            case (c)
                "@": return ".--.-.";
                "A": return ".-";
                "B": return "-...";
                "C": return "-.-.";
                "D": return "-..";
                "E": return ".";
                "F": return "..-.";
                "G": return "--.";
                "H": return "....";
                "I": return "..";
                "J": return ".---";
                "K": return "-.-";
                "L": return ".-..";
                "M": return "--";
                "N": return "-.";
                "O": return "---";
                "P": return ".--.";
                "Q": return "--.-";
                "R": return ".-.";
                "S": return "...";
                "T": return "-";
                "U": return "..-";
                "V": return "...-";
                "W": return ".--";
                "X": return "-..-";
                "Y": return "-.--";
                "Z": return "--..";
                ".": return ".-.-.-";
                ",": return "--..--";
                "/": return "-..-.";
                "1": return ".----";
                "2": return "..---";
                "3": return "...--";
                "4": return "....-";
                "5": return ".....";
                "6": return "-....";
                "7": return "--...";
                "8": return "---..";
                "9": return "----.";
                "0": return "-----";
                default: return "..--..";
            endcase
        endfunction

        function void push(logic led, logic [15:0] dur);
            interval_t iv;
            iv.led_on      = led;
            iv.duration_ms = dur;
            iv.run_end     = 1'b0;
            due_intervals.push_back(iv);
        endfunction

        function void push_flags();
            for (int i = 0; i < FLAG_PAIRS; i++) begin
                push(1'b1, timing[REG_FLAG]);
                push(1'b0, timing[REG_FLAG]);
            end
        endfunction

        function void note_char(logic [7:0] c, logic first, logic last);
            logic [7:0]  u;
            string       code;
            logic [15:0] end_gap;
            u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
            if (first) begin
                push(1'b0, timing[REG_FRAME_GAP]);
                push_flags();
                push(1'b0, timing[REG_FRAME_GAP]);
            end
            if (u == CHAR_SPACE || u == CHAR_LF) begin
                if (!last) begin
                    push(1'b0, timing[REG_WORD_GAP]);
                end
            end else begin
                code = morse_of(u);
                for (int k = 0; k < code.len(); k++) begin
                    push(1'b1, (code[k] == "-") ? timing[REG_DASH] : timing[REG_DOT]);
                    push(1'b0, timing[REG_ELEM_GAP]);
                end
                push(1'b0, timing[REG_LETTER_GAP]);
            end
            if (last) begin
                end_gap = (timing[REG_FRAME_GAP] > timing[REG_LETTER_GAP]) ?
                          timing[REG_FRAME_GAP] - timing[REG_LETTER_GAP] : 16'd0;
                push(1'b0, end_gap);
                push_flags();
                push(1'b0, timing[REG_FRAME_GAP]);
            end
            due_intervals[due_intervals.size() - 1].run_end = 1'b1;
        endfunction

        function void check_interval(logic led, logic [15:0] dur, logic run_end);
            interval_t want;
            if (due_intervals.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat led_on=%0d duration_ms=%0d run_end=%0d",
                         $time, led, dur, run_end);
                return;
            end
            want = due_intervals.pop_front();
            if (want.led_on !== led) begin
                errors++;
                $display("%0t: led_on expected %0d actual %0d", $time, want.led_on, led);
            end
            if (want.duration_ms !== dur) begin
                errors++;
                $display("%0t: duration_ms expected %0d actual %0d",
                         $time, want.duration_ms, dur);
            end
            if (want.run_end !== run_end) begin
                errors++;
                $display("%0t: run_end expected %0d actual %0d", $time, want.run_end, run_end);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_char_code;
    logic                  s_is_first;
    logic                  s_is_last;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_led_on;
    logic [15:0]           m_duration_ms;
    logic                  m_run_end;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_BITS-1:0]  paddr;
    logic [DATA_BITS-1:0]  pwdata;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    led_interval_book book;
    bit               quiet_run;
    int               cycle_count;

    morse_pulse_sequencer_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_is_first    (s_is_first),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_led_on      (m_led_on),
        .m_duration_ms (m_duration_ms),
        .m_run_end     (m_run_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    task automatic send_char(input logic [7:0] c, input logic first, input logic last);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_char_code = c;
        s_is_first  = first;
        s_is_last   = last;
        s_valid     = 1'b1;
        do @(posedge aclk); while (!s_ready);
        book.note_char(c, first, last);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (book.due_intervals.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_access(input logic write, input logic [2:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (write) begin
            book.set_timing(idx, wdata);
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic verify_timings();
        logic [31:0] rd;
        for (int r = REG_DOT; r <= REG_FRAME_GAP; r++) begin
            apb_access(1'b0, r[2:0], 32'd0, rd);
            if (rd[15:0] !== book.timing[r]) begin
                book.errors++;
                $display("%0t: register %0d readback expected %0d actual %0d",
                         $time, r, book.timing[r], rd[15:0]);
            end
        end
    endtask

    task automatic program_timings(input timing_profile_t profile);
        logic [31:0] rd;
        logic [15:0] value;
        logic [15:0] frame;
        frame = 16'($urandom_range(0, 65000));
        for (int r = REG_DOT; r <= REG_FRAME_GAP; r++) begin
            case (profile)
                TP_ZERO:  value = 16'd0;
                TP_MAX:   value = 16'hFFFF;
                TP_SHORT: value = 16'($urandom_range(0, 15));
                TP_LETTER_OVER_FRAME: begin
                    if (r == REG_FRAME_GAP) begin
                        value = frame;
                    end else if (r == REG_LETTER_GAP) begin
                        value = frame + 16'($urandom_range(0, 65535 - frame));
                    end else begin
                        value = 16'($urandom);
                    end
                end
                default:  value = 16'($urandom);
            endcase
            apb_access(1'b1, r[2:0], {16'($urandom), value}, rd);
        end
        apb_access(1'b1, REG_UNMAPPED, $urandom, rd);
        verify_timings();
    endtask

    function automatic logic [7:0] pick_char();
        int          roll;
        logic [7:0]  c;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            c = 8'("A" + $urandom_range(0, 25));
        end else if (roll < 55) begin
            c = 8'("a" + $urandom_range(0, 25));
        end else if (roll < 65) begin
            c = 8'("0" + $urandom_range(0, 9));
        end else if (roll < 72) begin
            case ($urandom_range(0, 4))
                0:       c = ".";
                1:       c = ",";
                2:       c = "/";
                3:       c = "?";
                default: c = "@";
            endcase
        end else if (roll < 82) begin
            c = $urandom_range(0, 1) ? CHAR_SPACE : CHAR_LF;
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = quiet_run ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            book.check_interval(m_led_on, m_duration_ms, m_run_end);
            @(negedge aclk);
        end
    end

    initial begin
        int              phase_items;
        int              msg_len;
        bit              drained;
        timing_profile_t profile;
        book        = new();
        quiet_run   = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_char_code = 8'd0;
        s_is_first  = 1'b0;
        s_is_last   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        verify_timings();
        send_char("A", 1'b1, 1'b1);
        send_char("z", 1'b1, 1'b0);
        send_char(CHAR_SPACE, 1'b0, 1'b0);
        send_char(CHAR_LF, 1'b0, 1'b0);
        send_char("?", 1'b0, 1'b0);
        send_char("@", 1'b0, 1'b0);
        send_char("0", 1'b0, 1'b0);
        send_char("9", 1'b0, 1'b0);
        send_char(".", 1'b0, 1'b0);
        send_char(",", 1'b0, 1'b0);
        send_char("/", 1'b0, 1'b0);
        send_char(8'h00, 1'b0, 1'b0);
        send_char(8'hFF, 1'b0, 1'b0);
        send_char(8'h80, 1'b0, 1'b0);
        send_char(8'h7F, 1'b0, 1'b0);
        send_char(CHAR_SPACE, 1'b0, 1'b1);
        send_char(CHAR_LF, 1'b1, 1'b1);
        send_char("e", 1'b0, 1'b1);
        settle();
        program_timings(TP_ZERO);
        send_char("T", 1'b1, 1'b1);
        settle();
        program_timings(TP_LETTER_OVER_FRAME);
        send_char("S", 1'b1, 1'b1);
        send_char(CHAR_SPACE, 1'b1, 1'b1);
        settle();
        program_timings(TP_MAX);
        send_char("5", 1'b1, 1'b1);
        send_char(8'hFF, 1'b1, 1'b1);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            case (phase % 5)
                0:       profile = TP_RANDOM;
                1:       profile = TP_SHORT;
                2:       profile = TP_LETTER_OVER_FRAME;
                3:       profile = TP_ZERO;
                default: profile = TP_MAX;
            endcase
            program_timings(profile);
            phase_items = 0;
            drained     = 1'b0;
            while (phase_items < PHASE_ITEMS) begin
                quiet_run = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 99) < 15) begin
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                    phase_items++;
                end else begin
                    msg_len = $urandom_range(1, 8);
                    for (int i = 0; i < msg_len; i++) begin
                        send_char(pick_char(), i == 0, i == msg_len - 1);
                    end
                    phase_items += msg_len;
                end
                if (!drained && phase_items >= PHASE_ITEMS / 2) begin
                    settle();
                    drained = 1'b1;
                end
            end
        end

        s_valid   = 1'b0;
        quiet_run = 1'b0;
        while (book.due_intervals.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (book.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/mps_pkg.sv
rtl/core/morse_pulse_sequencer_core.sv
rtl/core/mps_checker.sv
dv/tb.sv
